// ----- rtl/core/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and defaults for the segment loss tracker.
// ----------------------------------------------------------------------------
package slt_pkg;

  // Default sizes handed to the top level parameters
  localparam int unsigned MAX_DATAGRAM_DEF = 1400;
  localparam int unsigned MAX_MESSAGE_DEF  = 65536;
  localparam int unsigned INDEX_BITS_DEF   = 16;

  // Fixed field widths
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned TOT_W    = 16;
  localparam int unsigned SER_W    = 32;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned RBYTES_W = 17;
  localparam int unsigned CNT_W    = 32;

  // Packed stream widths, padded to whole bytes
  localparam int unsigned IN_BITS  = IDX_W + TOT_W + SER_W + LEN_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = SER_W + 1 + RBYTES_W + IDX_W + TOT_W + 3 * CNT_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Saturation value of the per-message lost count
  localparam logic [IDX_W-1:0] LOST_MAX = '1;

  // One received datagram
  typedef struct packed {
    logic [LEN_W-1:0] byte_len;
    logic [SER_W-1:0] msg_serial;
    logic [TOT_W-1:0] seg_total;
    logic [IDX_W-1:0] seg_index;
  } item_t;

  // One message report
  typedef struct packed {
    logic [CNT_W-1:0]    sum_lost;
    logic [CNT_W-1:0]    sum_expected;
    logic [CNT_W-1:0]    messages_done;
    logic [TOT_W-1:0]    report_expected;
    logic [IDX_W-1:0]    report_lost;
    logic [RBYTES_W-1:0] report_bytes;
    logic                first_missing;
    logic [SER_W-1:0]    report_serial;
  } report_t;

  // Saturating add for the lost count
  function automatic logic [IDX_W-1:0] sat_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[IDX_W] ? LOST_MAX : s[IDX_W-1:0];
  endfunction

endpackage

// ----- rtl/core/segment_loss_tracker_core.sv -----
// ----------------------------------------------------------------------------
// segment_loss_tracker_core
// Counts lost segments per message from received datagram headers.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per received datagram (index, segment count, serial,
//           length). A length of zero marks the end of a message.
//   out_* : one report beat each time a message closes, either on an end
//           mark or when the segment index goes backward. In the latter case
//           the same datagram opens the next message.
// Path: the closing datagram passes through the input register and then the
//   result register, which offers the report beat.
// Throughput: one datagram per cycle while the result register is empty or
//   out_tready is high; the whole update is compares and adds between the
//   input register and the result register.
// Reset: empties both registers and clears all message state and totals; no
//   message is open afterward.
// Stall: while out_tready is low a held report waits; the input register
//   takes one more beat and holds it, and in_tready stays low until the
//   report leaves.
// ----------------------------------------------------------------------------
module segment_loss_tracker_core #(
  parameter int unsigned MAX_DATAGRAM = slt_pkg::MAX_DATAGRAM_DEF,
  parameter int unsigned MAX_MESSAGE  = slt_pkg::MAX_MESSAGE_DEF,
  parameter int unsigned INDEX_BITS   = slt_pkg::INDEX_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // seg_index[15:0], seg_total[31:16], msg_serial[63:32], byte_len[74:64]
  input  logic [slt_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // report_serial[31:0], first_missing[32], report_bytes[49:33],
  // report_lost[65:50], report_expected[81:66], messages_done[113:82],
  // sum_expected[145:114], sum_lost[177:146]
  output logic [slt_pkg::OUT_W-1:0] out_tdata
);

  logic             item_valid;
  slt_pkg::item_t   item;
  logic             close;
  slt_pkg::report_t report;
  logic             out_free;
  logic             step;

  // Advance the held datagram whenever a report it may emit has room
  assign step = item_valid && out_free;

  slt_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .pop        (step),
    .item_valid (item_valid),
    .item       (item)
  );

  slt_tracker #(
    .MAX_DATAGRAM (MAX_DATAGRAM),
    .MAX_MESSAGE  (MAX_MESSAGE),
    .INDEX_BITS   (INDEX_BITS)
  ) u_trk (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .close  (close),
    .report (report)
  );

  slt_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && close),
    .report     (report),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/core/slt_in_stage.sv -----
// ----------------------------------------------------------------------------
// slt_in_stage
// Input register: captures one datagram beat and holds it until consumed.
// ----------------------------------------------------------------------------
module slt_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [slt_pkg::IN_W-1:0] in_tdata,
  input  logic                  pop,
  output logic                  item_valid,
  output slt_pkg::item_t        item
);

  logic           valid_r, valid_nxt;
  slt_pkg::item_t item_r;

  // Take a beat when empty or when the held one leaves this cycle
  assign in_tready = !valid_r || pop;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload until replaced
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_tdata[slt_pkg::IN_BITS-1:0];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- rtl/core/slt_tracker.sv -----
// ----------------------------------------------------------------------------
// slt_tracker
// Per-message state and running totals; builds the report on a close.
// ----------------------------------------------------------------------------
module slt_tracker #(
  parameter int unsigned MAX_DATAGRAM = slt_pkg::MAX_DATAGRAM_DEF,
  parameter int unsigned MAX_MESSAGE  = slt_pkg::MAX_MESSAGE_DEF,
  parameter int unsigned INDEX_BITS   = slt_pkg::INDEX_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  slt_pkg::item_t   item,
  output logic             close,
  output slt_pkg::report_t report
);

  localparam int unsigned IW = (INDEX_BITS < slt_pkg::IDX_W) ? INDEX_BITS : slt_pkg::IDX_W;
  localparam int unsigned BW = $clog2(MAX_MESSAGE + 1);
  localparam int unsigned SW = ((BW > slt_pkg::IDX_W) ? BW : slt_pkg::IDX_W) + 1;
  localparam logic [slt_pkg::IDX_W-1:0] DGRAM_MAX = slt_pkg::IDX_W'(MAX_DATAGRAM);
  localparam logic [SW-1:0]             MSG_MAX   = SW'(MAX_MESSAGE);
  localparam logic [BW-1:0]             MSG_CAP   = BW'(MAX_MESSAGE);

  localparam int unsigned TW = slt_pkg::TOT_W;
  localparam int unsigned CW = slt_pkg::CNT_W;
  localparam int unsigned LW = slt_pkg::IDX_W;

  logic          open_r,    open_nxt;
  logic [IW-1:0] last_r,    last_nxt;
  logic [TW-1:0] exp_r,     exp_nxt;
  logic [LW-1:0] lost_r,    lost_nxt;
  logic          head_r,    head_nxt;
  logic [slt_pkg::SER_W-1:0] serial_r, serial_nxt;
  logic [BW-1:0] bytes_r,   bytes_nxt;
  logic [CW-1:0] tot_exp_r, tot_exp_nxt;
  logic [CW-1:0] tot_lost_r, tot_lost_nxt;
  logic [CW-1:0] msg_cnt_r, msg_cnt_nxt;

  logic [IW-1:0] seg;
  logic          end_mark;
  logic [TW:0]   last_p1;
  logic [TW:0]   tail_diff;
  logic [LW-1:0] tail;
  logic [LW-1:0] closed_lost;
  logic [IW-1:0] gap;
  logic          open_base;
  logic [LW-1:0] lost_base;
  logic [BW-1:0] bytes_base;
  logic [LW-1:0] len_ext;
  logic [LW-1:0] len_clamp;
  logic [SW-1:0] bytes_sum;

  assign seg      = item.seg_index[IW-1:0];
  assign end_mark = (item.byte_len == '0);

  // Close on an end mark or a backward index while a message is open
  assign close = open_r && (end_mark || (seg < last_r));

  // Tail loss: announced count minus last index minus one, when positive
  assign last_p1     = (TW+1)'(last_r) + (TW+1)'(1);
  assign tail_diff   = {1'b0, exp_r} - last_p1;
  assign tail        = ({1'b0, exp_r} > last_p1) ? tail_diff[LW-1:0] : '0;
  assign closed_lost = slt_pkg::sat_add(lost_r, tail);

  // Report of the message being closed
  always_comb begin
    report.report_serial   = serial_r;
    report.first_missing   = head_r;
    report.report_bytes    = slt_pkg::RBYTES_W'(bytes_r);
    report.report_lost     = closed_lost;
    report.report_expected = exp_r;
    report.messages_done   = msg_cnt_r + CW'(1);
    report.sum_expected    = tot_exp_r + CW'(exp_r);
    report.sum_lost        = tot_lost_r + CW'(closed_lost);
  end

  // Datagram contribution
  assign gap        = seg - last_r - IW'(1);
  assign open_base  = open_r && !close;
  assign lost_base  = close ? '0 : lost_r;
  assign bytes_base = close ? '0 : bytes_r;
  assign len_ext    = LW'(item.byte_len);
  assign len_clamp  = (len_ext > DGRAM_MAX) ? DGRAM_MAX : len_ext;
  assign bytes_sum  = SW'(bytes_base) + SW'(len_clamp);

  always_comb begin
    open_nxt     = open_r;
    last_nxt     = last_r;
    exp_nxt      = exp_r;
    lost_nxt     = lost_r;
    head_nxt     = head_r;
    serial_nxt   = serial_r;
    bytes_nxt    = bytes_r;
    tot_exp_nxt  = tot_exp_r;
    tot_lost_nxt = tot_lost_r;
    msg_cnt_nxt  = msg_cnt_r;

    // Fold the closed message into the totals and clear it
    if (close) begin
      tot_exp_nxt  = report.sum_expected;
      tot_lost_nxt = report.sum_lost;
      msg_cnt_nxt  = report.messages_done;
      open_nxt     = 1'b0;
      exp_nxt      = '0;
      lost_nxt     = '0;
      head_nxt     = 1'b0;
      bytes_nxt    = '0;
    end

    // A data datagram opens or extends the message
    if (!end_mark) begin
      if (!open_base) begin
        head_nxt   = (seg != '0);
        serial_nxt = item.msg_serial;
        lost_nxt   = LW'(seg);
      end else if (seg > last_r) begin
        lost_nxt = slt_pkg::sat_add(lost_base, LW'(gap));
      end else begin
        lost_nxt = lost_base;
      end
      open_nxt  = 1'b1;
      last_nxt  = seg;
      exp_nxt   = item.seg_total;
      bytes_nxt = (bytes_sum > MSG_MAX) ? MSG_CAP : bytes_sum[BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= 1'b0;
      last_r     <= '0;
      exp_r      <= '0;
      lost_r     <= '0;
      head_r     <= 1'b0;
      serial_r   <= '0;
      bytes_r    <= '0;
      tot_exp_r  <= '0;
      tot_lost_r <= '0;
      msg_cnt_r  <= '0;
    end else if (step) begin
      open_r     <= open_nxt;
      last_r     <= last_nxt;
      exp_r      <= exp_nxt;
      lost_r     <= lost_nxt;
      head_r     <= head_nxt;
      serial_r   <= serial_nxt;
      bytes_r    <= bytes_nxt;
      tot_exp_r  <= tot_exp_nxt;
      tot_lost_r <= tot_lost_nxt;
      msg_cnt_r  <= msg_cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/slt_out_stage.sv -----
// ----------------------------------------------------------------------------
// slt_out_stage
// Result register: holds one report beat until the receiver takes it.
// ----------------------------------------------------------------------------
module slt_out_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  slt_pkg::report_t          report,
  output logic                      free,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [slt_pkg::OUT_W-1:0] out_tdata
);

  logic             valid_r, valid_nxt;
  slt_pkg::report_t data_r;

  // Room for a new report when empty or when the held one leaves
  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= report;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = slt_pkg::OUT_W'(data_r);

endmodule
